### hw/rtl/swl_pkg.sv
// Package: shared constants, types and codes of the sliding-window-log rate limiter.
`default_nettype none

package swl_pkg;

   localparam int FLOWS     = 256;
   localparam int MAX_LIMIT = 16;
   localparam int FLOW_W    = $clog2(FLOWS);
   localparam int SLOT_W    = $clog2(MAX_LIMIT);
   localparam int CNT_W     = $clog2(MAX_LIMIT + 1);
   localparam int LOG_W     = FLOW_W + SLOT_W;
   localparam int TIME_W    = 31;
   localparam int LIMIT_W   = 5;
   localparam int CSR_W     = 31;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 8;

   localparam logic [LIMIT_W-1:0] MAX_REQUESTS_RST  = LIMIT_W'(3);
   localparam logic [TIME_W-1:0]  WINDOW_LENGTH_RST = TIME_W'(1000);

   typedef enum logic {
      CSR_MAX_REQUESTS  = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } csr_addr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK
   } swl_state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic pop;
      logic commit;
   } swl_cmd_type;

   typedef struct packed {
      logic expired;
      logic out_free;
   } swl_sts_type;

endpackage

`default_nettype wire

### hw/rtl/sliding_window_log_rate_limiter.sv
// Top level of the per-flow sliding-window-log rate limiter.
// A request is taken in ST_IDLE, reads its flow's head and count and then the oldest time log
// entry in ST_LOOKUP, and in ST_CHECK drops expired entries before the decision is registered.
// One request at a time: a new request is taken only once the previous one has been decided.
// A result waiting in the output register only holds the block at the decision of the next one.
// Reset: synchronous, active high; clears per-flow counts via valid bits, config to defaults.
`default_nettype none

module sliding_window_log_rate_limiter
   import swl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [REQ_W-1:0]   req_tdata,  // [7:0] flow_id, [38:8] request_time, [39] unused
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata   // [0] allowed, [7:1] zero
);

   swl_cmd_type cmd;
   swl_sts_type sts;

   swl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   swl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

### hw/rtl/swl_ctrl.sv
// Controller: sequences lookup, expiry pops and commit for one request at a time.
`default_nettype none

module swl_ctrl
   import swl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire swl_sts_type sts,
   output swl_cmd_type      cmd
);

   swl_state_type state_ff;
   swl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            // drop expired entries one per cycle, then decide once the result slot is free
            if (sts.expired) begin
               cmd.pop = 1'b1;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/swl_dp.sv
// Datapath: config registers, per-flow head/count store, time log memory and result register.
`default_nettype none

module swl_dp
   import swl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   input  wire logic [REQ_W-1:0]   req_tdata,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,
   input  wire swl_cmd_type        cmd,
   output swl_sts_type             sts
);

   logic [LIMIT_W-1:0]       max_requests_ff;
   logic [TIME_W-1:0]        window_length_ff;

   logic [FLOW_W-1:0]        flow_ff;
   logic [TIME_W-1:0]        now_ff;
   logic [SLOT_W-1:0]        head_ff;
   logic [SLOT_W-1:0]        head_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;

   logic [SLOT_W+CNT_W-1:0]  fs_mem [FLOWS];
   logic [SLOT_W+CNT_W-1:0]  fs_rd_ff;
   logic [FLOWS-1:0]         fs_vld_ff;
   logic                     fs_vld_rd_ff;

   logic [TIME_W-1:0]        time_mem [FLOWS*MAX_LIMIT];
   logic [TIME_W-1:0]        time_rd_ff;
   logic [LOG_W-1:0]         time_raddr;
   logic [LOG_W-1:0]         time_waddr;

   logic                     rsp_tvalid_ff;
   logic                     allowed_ff;

   logic [FLOW_W-1:0]        req_flow;
   logic [TIME_W-1:0]        req_time;
   logic [SLOT_W-1:0]        lk_head;
   logic [CNT_W-1:0]         lk_count;
   logic [LIMIT_W-1:0]       limit;
   logic                     admit;
   logic [SLOT_W-1:0]        tail;
   logic [TIME_W:0]          expiry;

   assign req_flow = req_tdata[FLOW_W-1:0];
   assign req_time = req_tdata[FLOW_W+TIME_W-1:FLOW_W];

   // a flow never written since reset reads as an empty log
   assign lk_head  = fs_vld_rd_ff ? fs_rd_ff[SLOT_W+CNT_W-1:CNT_W] : '0;
   assign lk_count = fs_vld_rd_ff ? fs_rd_ff[CNT_W-1:0] : '0;

   assign limit  = (max_requests_ff > LIMIT_W'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT)
                                                           : max_requests_ff;
   assign admit  = (LIMIT_W'(count_ff) < limit);
   assign tail   = head_ff + count_ff[SLOT_W-1:0];
   assign expiry = {1'b0, time_rd_ff} + {1'b0, window_length_ff};

   assign sts.expired  = (count_ff != '0) && (expiry <= {1'b0, now_ff});
   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.lookup) begin
         head_in  = lk_head;
         count_in = lk_count;
      end else if (cmd.pop) begin
         head_in  = head_ff + SLOT_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign time_raddr = {flow_ff, head_in};
   assign time_waddr = {flow_ff, tail};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_requests_ff  <= MAX_REQUESTS_RST;
         window_length_ff <= WINDOW_LENGTH_RST;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_MAX_REQUESTS:  max_requests_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         flow_ff <= req_flow;
         now_ff  <= req_time;
      end
      head_ff  <= head_in;
      count_ff <= count_in;
   end

   // per-flow head and count store
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         fs_mem[flow_ff] <= {head_ff, admit ? count_ff + CNT_W'(1) : count_ff};
      end
      if (cmd.load) begin
         fs_rd_ff <= fs_mem[req_flow];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_vld_ff    <= '0;
         fs_vld_rd_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            fs_vld_ff[flow_ff] <= 1'b1;
         end
         if (cmd.load) begin
            fs_vld_rd_ff <= fs_vld_ff[req_flow];
         end
      end
   end

   // time log: one ring of MAX_LIMIT slots per flow
   always_ff @(posedge clock) begin
      if (cmd.commit && admit) begin
         time_mem[time_waddr] <= now_ff;
      end
      time_rd_ff <= time_mem[time_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         allowed_ff <= admit;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, allowed_ff};

endmodule

`default_nettype wire

### hw/rtl/swl_props.sv
// Port-level assertions for the rate limiter, bound to the top level.
`default_nettype none

module swl_props
   import swl_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_W-1:0]  rsp_tdata
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result survives reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one request at a time: lookup and check follow each transfer
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken during lookup");

   // only the allowed bit carries information
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:1] == '0)
      else $error("result padding not zero");

endmodule

bind sliding_window_log_rate_limiter swl_props u_swl_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
